@@ hdl/hop_pkg.sv @@
// Shared types and constants for the associative memory block.
`timescale 1ns / 1ps

package hop_pkg;

  localparam int PAT_W = 16;
  localparam int W_W = 6;
  localparam int RND_W = 16;
  localparam logic [RND_W-1:0] ROUNDS_RESET = 16'd1024;

  typedef enum logic [1:0] {
    OP_TRAIN  = 2'd0,
    OP_RECALL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // weight store control
  typedef struct packed {
    logic rd;
    logic we;
    logic mark;
    logic clear;
  } wm_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TRAIN  = 5'b00010,
    S_RECALL = 5'b00100,
    S_CHECK  = 5'b01000,
    S_OUT2   = 5'b10000
  } fsm_t;

endpackage

@@ hdl/hop_wmem.sv @@
// Weight store: one read and one write port, per-row valid bits.
`timescale 1ns / 1ps

module hop_wmem
  import hop_pkg::*;
#(
  parameter int NEURONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wm_ctl_t               ctl,
  input  logic [$clog2(NEURONS)-1:0] rj,
  input  logic [$clog2(NEURONS)-1:0] ri,
  input  logic [$clog2(NEURONS)-1:0] wj,
  input  logic [$clog2(NEURONS)-1:0] wi,
  input  logic signed [W_W-1:0] wdata,
  output logic signed [W_W-1:0] rdata
);

  localparam int NW = $clog2(NEURONS);
  localparam int DEPTH = 1 << (2 * NW);

  logic signed [W_W-1:0] mem [DEPTH];
  logic [NEURONS-1:0]    row_vld;
  logic signed [W_W-1:0] mem_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      mem_q <= mem[{rj, ri}];
    end
    if (ctl.we) begin
      mem[{wj, wi}] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.rd) begin
        vld_q <= row_vld[rj];
      end
      if (ctl.clear) begin
        row_vld <= '0;
      end else if (ctl.mark) begin
        row_vld[wj] <= 1'b1;
      end
    end
  end

  // unwritten rows read as zero
  assign rdata = vld_q ? mem_q : '0;

endmodule

@@ hdl/hop_mac.sv @@
// Shared adder: Hebbian weight update or signed accumulate of one weight.
`timescale 1ns / 1ps

module hop_mac
  import hop_pkg::*;
#(
  parameter int NEURONS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  train,
  input  logic                  first,
  input  logic                  pos,
  input  logic signed [W_W-1:0] w,
  output logic                  nonneg,
  output logic signed [W_W-1:0] wsat
);

  localparam int ACC_W = W_W + $clog2(NEURONS) + 1;
  localparam logic signed [ACC_W-1:0] WMAX = ACC_W'(31);
  localparam logic signed [ACC_W-1:0] WMIN = -ACC_W'(32);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] wx;
  logic signed [ACC_W-1:0] opa;
  logic signed [ACC_W-1:0] opb;
  logic signed [ACC_W-1:0] sum;

  always_comb begin
    wx = ACC_W'(w);
    if (train) begin
      opa = wx;
      opb = pos ? ACC_W'(1) : -ACC_W'(1);
    end else begin
      opa = first ? '0 : acc;
      opb = pos ? wx : -wx;
    end
    sum = opa + opb;
    if (sum > WMAX) begin
      wsat = W_W'(WMAX);
    end else if (sum < WMIN) begin
      wsat = W_W'(WMIN);
    end else begin
      wsat = W_W'(sum);
    end
  end

  assign nonneg = ~sum[ACC_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= sum;
    end
  end

endmodule

@@ hdl/hopfield_associative_memory.sv @@
// Top level: binary associative memory with Hebbian training and synchronous recall.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Clear and a train
// request refused because the memory is full finish at once, with the result
// strobed on done in the next cycle. A stored train request walks all
// NEURONS*NEURONS weights once; recall walks them once per update round,
// for up to max_rounds rounds (zero counts as one), then a check state
// gives the result. Both walks go through the single shared adder, which
// handles one weight per cycle out of the one-read, one-write weight store.
// An oscillation gives two results on consecutive cycles, older state first.
// Results cannot be held off: each one is valid for the single cycle that
// done is high. max_rounds is written over cfg_valid/cfg_ready (always ready)
// and must only change while idle.
module hopfield_associative_memory
  import hop_pkg::*;
#(
  parameter int NEURONS = 16,
  parameter int MAX_PATTERNS = 16,
  parameter int HISTORY_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       operation,
  input  logic [PAT_W-1:0] pattern,
  output logic             done,
  output logic [PAT_W-1:0] state,
  output logic             is_cycle,
  output logic             timed_out,
  output logic             accepted,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RND_W-1:0] max_rounds
);

  localparam int NW = $clog2(NEURONS);
  localparam int PC_W = $clog2(MAX_PATTERNS + 1);
  localparam logic [NW-1:0] LAST_IDX = NW'(NEURONS - 1);

  fsm_t fsm;
  logic issuing;
  logic [NW-1:0] ci;
  logic [NW-1:0] cj;
  logic p_valid;
  logic [NW-1:0] p_i;
  logic [NW-1:0] p_j;
  logic p_row_end;
  logic p_last;
  logic [NEURONS-1:0] newer;
  logic [NEURONS-1:0] older;
  logic [NEURONS-1:0] nxt;
  logic hv2;
  logic [RND_W-1:0] rcount;
  logic [RND_W-1:0] rounds_limit;
  logic [PC_W-1:0] pattern_count;

  logic accept;
  wm_ctl_t wm_ctl;
  logic signed [W_W-1:0] rdata;
  logic signed [W_W-1:0] wsat;
  logic signed [W_W-1:0] wdata;
  logic nonneg;
  logic mac_pos;
  logic [NEURONS+PAT_W-1:0] pat_ext;
  logic [NEURONS-1:0] pat_n;
  logic [NEURONS+PAT_W-1:0] older_ext;
  logic [NEURONS+PAT_W-1:0] newer_ext;
  logic [NEURONS+PAT_W-1:0] nxt_ext;
  logic [RND_W-1:0] limit;
  logic round_out;

  assign busy = (fsm != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start & ~busy;

  assign pat_ext = {{NEURONS{1'b0}}, pattern};
  assign pat_n = pat_ext[NEURONS-1:0];
  assign older_ext = {{PAT_W{1'b0}}, older};
  assign newer_ext = {{PAT_W{1'b0}}, newer};
  assign nxt_ext = {{PAT_W{1'b0}}, nxt};

  assign limit = (rounds_limit == '0) ? RND_W'(1) : rounds_limit;
  assign round_out = ({1'b0, rcount} + (RND_W+1)'(1)) >= {1'b0, limit};

  always_comb begin
    wm_ctl.rd = issuing;
    wm_ctl.we = p_valid & (fsm == S_TRAIN);
    wm_ctl.mark = p_valid & (fsm == S_TRAIN) & p_row_end;
    wm_ctl.clear = accept & (operation == OP_CLEAR);
  end

  assign mac_pos = (fsm == S_TRAIN) ? ~(newer[p_i] ^ newer[p_j]) : newer[p_i];
  assign wdata = (p_i == p_j) ? '0 : wsat;

  hop_wmem #(
    .NEURONS(NEURONS)
  ) u_wmem (
    .clk  (clk),
    .rst  (rst),
    .ctl  (wm_ctl),
    .rj   (cj),
    .ri   (ci),
    .wj   (p_j),
    .wi   (p_i),
    .wdata(wdata),
    .rdata(rdata)
  );

  hop_mac #(
    .NEURONS(NEURONS)
  ) u_mac (
    .clk   (clk),
    .en    (p_valid & (fsm == S_RECALL)),
    .train (fsm == S_TRAIN),
    .first (p_i == '0),
    .pos   (mac_pos),
    .w     (rdata),
    .nonneg(nonneg),
    .wsat  (wsat)
  );

  // read address walk, one weight per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issuing;
    end
    p_i <= ci;
    p_j <= cj;
    p_row_end <= (ci == LAST_IDX);
    p_last <= (ci == LAST_IDX) && (cj == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
      issuing <= 1'b0;
      ci <= '0;
      cj <= '0;
      done <= 1'b0;
      pattern_count <= '0;
      rounds_limit <= ROUNDS_RESET;
      hv2 <= 1'b0;
      rcount <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        rounds_limit <= max_rounds;
      end
      if (issuing) begin
        if (ci == LAST_IDX) begin
          ci <= '0;
          if (cj == LAST_IDX) begin
            issuing <= 1'b0;
          end else begin
            cj <= cj + NW'(1);
          end
        end else begin
          ci <= ci + NW'(1);
        end
      end
      if (p_valid && (fsm == S_RECALL) && p_row_end) begin
        nxt[p_j] <= nonneg;
      end
      case (fsm)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_TRAIN: begin
                if (pattern_count >= PC_W'(MAX_PATTERNS)) begin
                  done <= 1'b1;
                  state <= '0;
                  is_cycle <= 1'b0;
                  timed_out <= 1'b0;
                  accepted <= 1'b0;
                  last <= 1'b1;
                end else begin
                  newer <= pat_n;
                  issuing <= 1'b1;
                  ci <= '0;
                  cj <= '0;
                  fsm <= S_TRAIN;
                end
              end
              OP_RECALL: begin
                newer <= pat_n;
                older <= '0;
                hv2 <= 1'b0;
                rcount <= '0;
                issuing <= 1'b1;
                ci <= '0;
                cj <= '0;
                fsm <= S_RECALL;
              end
              OP_CLEAR: begin
                pattern_count <= '0;
                done <= 1'b1;
                state <= '0;
                is_cycle <= 1'b0;
                timed_out <= 1'b0;
                accepted <= 1'b1;
                last <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_TRAIN: begin
          if (p_valid && p_last) begin
            pattern_count <= pattern_count + PC_W'(1);
            done <= 1'b1;
            state <= '0;
            is_cycle <= 1'b0;
            timed_out <= 1'b0;
            accepted <= 1'b1;
            last <= 1'b1;
            fsm <= S_IDLE;
          end
        end
        S_RECALL: begin
          if (p_valid && p_last) begin
            fsm <= S_CHECK;
          end
        end
        S_CHECK: begin
          timed_out <= 1'b0;
          accepted <= 1'b1;
          if ((HISTORY_DEPTH >= 2) && hv2 && (nxt == older)) begin
            done <= 1'b1;
            state <= older_ext[PAT_W-1:0];
            is_cycle <= 1'b1;
            last <= 1'b0;
            fsm <= S_OUT2;
          end else if (nxt == newer) begin
            done <= 1'b1;
            state <= newer_ext[PAT_W-1:0];
            is_cycle <= 1'b0;
            last <= 1'b1;
            fsm <= S_IDLE;
          end else begin
            older <= newer;
            newer <= nxt;
            hv2 <= 1'b1;
            if (round_out) begin
              done <= 1'b1;
              state <= nxt_ext[PAT_W-1:0];
              is_cycle <= 1'b0;
              timed_out <= 1'b1;
              last <= 1'b1;
              fsm <= S_IDLE;
            end else begin
              rcount <= rcount + RND_W'(1);
              issuing <= 1'b1;
              ci <= '0;
              cj <= '0;
              fsm <= S_RECALL;
            end
          end
        end
        S_OUT2: begin
          done <= 1'b1;
          state <= newer_ext[PAT_W-1:0];
          is_cycle <= 1'b1;
          timed_out <= 1'b0;
          accepted <= 1'b1;
          last <= 1'b1;
          fsm <= S_IDLE;
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && last && is_cycle)
    else $error("oscillation result pair not completed");

  a_cycle_no_timeout: assert property (@(posedge clk) disable iff (rst)
    done && is_cycle |-> !timed_out && accepted)
    else $error("oscillation result flagged as timeout");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_count <= PC_W'(MAX_PATTERNS))
    else $error("pattern count above limit");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    done && !accepted |-> last && (state == '0) && ($past(pattern_count) ==
      PC_W'(MAX_PATTERNS)))
    else $error("train refused while memory not full");

  a_walk_idle: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_IDLE) |-> !issuing && !p_valid)
    else $error("weight walk active while idle");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the associative memory: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import hop_pkg::*;

  localparam int NEURONS = 16;
  localparam int MAX_PATTERNS = 16;
  localparam int HISTORY_DEPTH = 2;
  localparam int ROUND_CYCLES = NEURONS * NEURONS + 3;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic [PAT_W-1:0] state;
    logic             is_cycle;
    logic             timed_out;
    logic             accepted;
    logic             last;
  } mem_result_t;

  // how the expected result of a request is obtained
  typedef enum logic [1:0] {
    EXP_MODEL   = 2'd0,
    EXP_ACK     = 2'd1,
    EXP_REFUSED = 2'd2,
    EXP_ONES    = 2'd3
  } exp_kind_t;

  typedef struct packed {
    op_t              op;
    logic [PAT_W-1:0] pat;
    exp_kind_t        kind;
  } dir_row_t;

  localparam dir_row_t [0:DIR_ROWS-1] DIR_TABLE = {
    {OP_RECALL, 16'h0000, EXP_ONES},
    {OP_RECALL, 16'hFFFF, EXP_ONES},
    {OP_NONE,   16'h1234, EXP_MODEL},
    {OP_TRAIN,  16'h0000, EXP_ACK},
    {OP_TRAIN,  16'hFFFF, EXP_ACK},
    {OP_TRAIN,  16'h00FF, EXP_ACK},
    {OP_RECALL, 16'h00FE, EXP_MODEL},
    {OP_TRAIN,  16'h0F0F, EXP_ACK},
    {OP_TRAIN,  16'h3333, EXP_ACK},
    {OP_RECALL, 16'h3331, EXP_MODEL},
    {OP_TRAIN,  16'h5555, EXP_ACK},
    {OP_TRAIN,  16'hA5A5, EXP_ACK},
    {OP_TRAIN,  16'h8001, EXP_ACK},
    {OP_TRAIN,  16'h7FFE, EXP_ACK},
    {OP_TRAIN,  16'h1248, EXP_ACK},
    {OP_TRAIN,  16'hC3C3, EXP_ACK},
    {OP_TRAIN,  16'h6996, EXP_ACK},
    {OP_TRAIN,  16'hDEAD, EXP_ACK},
    {OP_TRAIN,  16'hBEEF, EXP_ACK},
    {OP_TRAIN,  16'h0123, EXP_ACK},
    {OP_TRAIN,  16'hFEDC, EXP_ACK},
    {OP_RECALL, 16'h00FF, EXP_MODEL},
    {OP_TRAIN,  16'h1234, EXP_REFUSED},
    {OP_CLEAR,  16'h0000, EXP_ACK},
    {OP_RECALL, 16'h8000, EXP_ONES}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       operation = OP_TRAIN;
  logic [PAT_W-1:0] pattern = '0;
  logic             cfg_valid = 1'b0;
  logic [RND_W-1:0] cfg_rounds = '0;
  exp_kind_t        req_kind = EXP_MODEL;
  logic             busy;
  logic             done;
  logic [PAT_W-1:0] state;
  logic             is_cycle;
  logic             timed_out;
  logic             accepted;
  logic             last;
  logic             cfg_ready;

  // predictor state
  int               wgt [NEURONS][NEURONS];
  int               stored_cnt;
  logic [RND_W-1:0] rounds_cfg = ROUNDS_RESET;
  int               rounds_used;
  mem_result_t      step_out [$];
  mem_result_t      due_results [$];
  logic [PAT_W-1:0] kept_patterns [$];
  int               mismatch_count = 0;
  int               quiet_cycles = 0;
  int               quiet_limit = 4000;

  hopfield_associative_memory #(
    .NEURONS(NEURONS),
    .MAX_PATTERNS(MAX_PATTERNS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .pattern(pattern),
    .done(done),
    .state(state),
    .is_cycle(is_cycle),
    .timed_out(timed_out),
    .accepted(accepted),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .max_rounds(cfg_rounds)
  );

  always #4 clk = ~clk;

  function automatic logic [PAT_W-1:0] next_state(logic [PAT_W-1:0] cur);
    logic [PAT_W-1:0] nxt;
    int acc;
    nxt = '0;
    for (int j = 0; j < NEURONS; j++) begin
      acc = 0;
      for (int i = 0; i < NEURONS; i++) begin
        if (i != j) acc += wgt[j][i] * (cur[i] ? 1 : -1);
      end
      nxt[j] = (acc >= 0);
    end
    return nxt;
  endfunction

  function automatic void add_step(input mem_result_t r);
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic void add_due(input mem_result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  task automatic clear_memory();
    for (int j = 0; j < NEURONS; j++)
      for (int i = 0; i < NEURONS; i++) wgt[j][i] = 0;
    stored_cnt = 0;
  endtask

  // works out the results of one request and updates the memory image
  task automatic memory_step(input logic [1:0] op, input logic [PAT_W-1:0] pat);
    logic [PAT_W-1:0] older;
    logic [PAT_W-1:0] newer;
    logic [PAT_W-1:0] nxt;
    int valid;
    int lim;
    int r;
    int w;
    bit settled;
    step_out.delete();
    rounds_used = 1;
    case (op)
      OP_TRAIN: begin
        if (stored_cnt >= MAX_PATTERNS) begin
          add_step({16'h0000, 1'b0, 1'b0, 1'b0, 1'b1});
        end else begin
          for (int j = 0; j < NEURONS; j++) begin
            for (int i = 0; i < NEURONS; i++) begin
              if (i != j) begin
                w = wgt[j][i] + ((pat[i] == pat[j]) ? 1 : -1);
                if (w > 31) w = 31;
                if (w < -32) w = -32;
                wgt[j][i] = w;
              end
            end
          end
          stored_cnt++;
          add_step({16'h0000, 1'b0, 1'b0, 1'b1, 1'b1});
        end
      end
      OP_CLEAR: begin
        clear_memory();
        add_step({16'h0000, 1'b0, 1'b0, 1'b1, 1'b1});
      end
      OP_RECALL: begin
        newer = pat;
        older = '0;
        valid = 1;
        settled = 1'b0;
        lim = (rounds_cfg == 0) ? 1 : int'(rounds_cfg);
        for (r = 0; r < lim && !settled; r++) begin
          nxt = next_state(newer);
          if (HISTORY_DEPTH >= 2 && valid >= 2 && nxt == older) begin
            add_step({older, 1'b1, 1'b0, 1'b1, 1'b0});
            add_step({newer, 1'b1, 1'b0, 1'b1, 1'b1});
            settled = 1'b1;
          end else if (nxt == newer) begin
            add_step({newer, 1'b0, 1'b0, 1'b1, 1'b1});
            settled = 1'b1;
          end else begin
            older = newer;
            newer = nxt;
            if (valid < HISTORY_DEPTH) valid++;
          end
        end
        rounds_used = r;
        if (!settled) add_step({newer, 1'b0, 1'b1, 1'b1, 1'b1});
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    mem_result_t want;
    mem_result_t got;
    mem_result_t fixed;
    if (rst) begin
      clear_memory();
      rounds_cfg = ROUNDS_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (done) begin
        quiet_cycles = 0;
        got = {state, is_cycle, timed_out, accepted, last};
        if (due_results.size() == 0) begin
          $error("unexpected result: state %h", state);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (got.state !== want.state) begin
            $error("state: expected %h, actual %h", want.state, got.state);
            mismatch_count++;
          end
          if (got.is_cycle !== want.is_cycle) begin
            $error("is_cycle: expected %b, actual %b", want.is_cycle, got.is_cycle);
            mismatch_count++;
          end
          if (got.timed_out !== want.timed_out) begin
            $error("timed_out: expected %b, actual %b", want.timed_out, got.timed_out);
            mismatch_count++;
          end
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %b, actual %b", want.accepted, got.accepted);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, got.last);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        memory_step(operation, pattern);
        case (req_kind)
          EXP_ACK:     fixed = {16'h0000, 1'b0, 1'b0, 1'b1, 1'b1};
          EXP_REFUSED: fixed = {16'h0000, 1'b0, 1'b0, 1'b0, 1'b1};
          EXP_ONES:    fixed = {16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1};
          default:     fixed = '0;
        endcase
        if (req_kind == EXP_MODEL) begin
          foreach (step_out[i]) add_due(step_out[i]);
        end else begin
          add_due(fixed);
        end
        quiet_limit = 4 * (rounds_used + 1) * ROUND_CYCLES + 2000;
      end
      if (cfg_valid && cfg_ready) begin
        rounds_cfg = cfg_rounds;
        quiet_cycles = 0;
      end
      if (quiet_cycles > quiet_limit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [PAT_W-1:0] pat,
                          input exp_kind_t kind);
    start <= 1'b1;
    operation <= op;
    pattern <= pat;
    req_kind <= kind;
    do @(posedge clk); while (busy);
    if (op == OP_TRAIN && kept_patterns.size() < MAX_PATTERNS)
      kept_patterns.insert(kept_patterns.size(), pat);
    if (op == OP_CLEAR) kept_patterns.delete();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_rounds(input logic [RND_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_rounds <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [RND_W-1:0] setting;
    logic [PAT_W-1:0] p;
    int draw;
    int flips;
    int b;
    int clear_pct;
    bit idle_on;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++)
      send_req(DIR_TABLE[k].op, DIR_TABLE[k].pat, DIR_TABLE[k].kind);

    idle_on = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        0: setting = 16'd1;
        1: setting = 16'd0;
        2: setting = 16'hFFFF;
        3: setting = 16'd2;
        4: setting = RND_W'($urandom_range(3, 12));
        5: setting = 16'd3;
        6: setting = 16'hFFFE;
        default: setting = ROUNDS_RESET;
      endcase
      set_rounds(setting);
      clear_pct = (ph % 2) ? 2 : 8;
      for (int n = 0; n < 70; n++) begin
        if (n == 35) drain_results();
        if (n % 10 == 0) idle_on = (ph != 7) && ($urandom_range(1) == 1);
        draw = $urandom_range(99);
        if (draw < 40 && kept_patterns.size() > 0) begin
          // noisy probe of a stored pattern or its complement
          p = kept_patterns[$urandom_range(kept_patterns.size() - 1)];
          if ($urandom_range(3) == 0) p = ~p;
          flips = $urandom_range(3);
          repeat (flips) begin
            b = $urandom_range(PAT_W - 1);
            p[b] = ~p[b];
          end
          send_req(OP_RECALL, p, EXP_MODEL);
        end else if (draw < 55) begin
          send_req(OP_RECALL, PAT_W'($urandom), EXP_MODEL);
        end else if (draw < 97 - clear_pct) begin
          send_req(OP_TRAIN, PAT_W'($urandom), EXP_MODEL);
        end else if (draw < 97) begin
          send_req(OP_CLEAR, PAT_W'($urandom), EXP_MODEL);
        end else begin
          send_req(OP_NONE, PAT_W'($urandom), EXP_MODEL);
        end
        if (idle_on && $urandom_range(2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (NEURONS * NEURONS + 8) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
